// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, sampled at the rising edge, off during reset.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: hdl/ptk_pkg.sv
// ----------------------------------------------------------------------------
// ptk_pkg
// Types and constants of the per-device min/max tracker.
// ----------------------------------------------------------------------------
package ptk_pkg;

  localparam int DevIdBits = 4;
  localparam int CountBits = 32;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the accepted request into the input registers
    logic read;     // read the addressed table entry
    logic commit;   // write the entry back and load the output register
  } ctrl_t;

endpackage

// File: hdl/ptk_in_if.sv
// ----------------------------------------------------------------------------
// ptk_in_if
// Request channel: command, device number and sample.
// ----------------------------------------------------------------------------
interface ptk_in_if #(
  parameter int VALUE_BITS = 32
);
  import ptk_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [DevIdBits-1:0]         device_id;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, cmd, device_id, sample_value, input ready);
  modport sink   (input valid, cmd, device_id, sample_value, output ready);
endinterface

// File: hdl/ptk_out_if.sv
// ----------------------------------------------------------------------------
// ptk_out_if
// Result channel: seen flag, count, minimum and maximum of one device.
// ----------------------------------------------------------------------------
interface ptk_out_if #(
  parameter int VALUE_BITS = 32
);
  import ptk_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         seen;
  logic [CountBits-1:0]         event_count;
  logic signed [VALUE_BITS-1:0] min_seen;
  logic signed [VALUE_BITS-1:0] max_seen;

  modport source (output valid, seen, event_count, min_seen, max_seen, input ready);
  modport sink   (input valid, seen, event_count, min_seen, max_seen, output ready);
endinterface

// File: hdl/ptk_ctrl.sv
// ----------------------------------------------------------------------------
// ptk_ctrl
// Sequencer: accept, read the table entry, then commit the update and result.
// ----------------------------------------------------------------------------
module ptk_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ptk_pkg::ctrl_t ctrl_o
);
  import ptk_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctrl_o         = '0;
    out_valid_d    = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.read = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/ptk_datapath.sv
// ----------------------------------------------------------------------------
// ptk_datapath
// Statistics table, min/max/count update and the result register.
// ----------------------------------------------------------------------------
module ptk_datapath #(
  parameter int DEVICES    = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptk_pkg::ctrl_t                ctrl_i,
  input  logic                          cmd_i,
  input  logic [ptk_pkg::DevIdBits-1:0] device_id_i,
  input  logic signed [VALUE_BITS-1:0]  sample_value_i,
  output logic                          seen_o,
  output logic [ptk_pkg::CountBits-1:0] event_count_o,
  output logic signed [VALUE_BITS-1:0]  min_seen_o,
  output logic signed [VALUE_BITS-1:0]  max_seen_o
);
  import ptk_pkg::*;

  // Only the entries a device number can reach are built.
  localparam int Entries = (DEVICES < (1 << DevIdBits)) ? DEVICES : (1 << DevIdBits);
  localparam int IdxBits = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [CountBits-1:0] CountTop = '1;

  // Input registers.
  logic                         cmd_q;
  logic [DevIdBits-1:0]         dev_q;
  logic signed [VALUE_BITS-1:0] val_q;

  // Table: one valid bit per entry stands for a nonzero count.
  logic [Entries-1:0]           valid_q;
  logic [CountBits-1:0]         cnt_mem [Entries];
  logic signed [VALUE_BITS-1:0] min_mem [Entries];
  logic signed [VALUE_BITS-1:0] max_mem [Entries];

  // Registered read of the addressed entry.
  logic                         rd_seen_q;
  logic [CountBits-1:0]         rd_cnt_q;
  logic signed [VALUE_BITS-1:0] rd_min_q;
  logic signed [VALUE_BITS-1:0] rd_max_q;

  // Result register.
  logic                         seen_q;
  logic [CountBits-1:0]         cnt_q;
  logic signed [VALUE_BITS-1:0] min_q;
  logic signed [VALUE_BITS-1:0] max_q;

  logic                         in_range;
  logic [IdxBits-1:0]           idx;
  logic                         record;
  logic [CountBits-1:0]         new_cnt;
  logic signed [VALUE_BITS-1:0] new_min;
  logic signed [VALUE_BITS-1:0] new_max;

  assign in_range = {1'b0, dev_q} < (DevIdBits + 1)'(Entries);
  assign idx      = dev_q[IdxBits-1:0];
  assign record   = (cmd_q == CMD_RECORD) && in_range;

  always_comb begin
    if (!rd_seen_q) begin
      new_cnt = CountBits'(1);
      new_min = val_q;
      new_max = val_q;
    end else begin
      new_cnt = (rd_cnt_q == CountTop) ? rd_cnt_q : rd_cnt_q + CountBits'(1);
      new_min = (val_q < rd_min_q) ? val_q : rd_min_q;
      new_max = (val_q > rd_max_q) ? val_q : rd_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.commit && record) begin
      valid_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      dev_q <= device_id_i;
      val_q <= sample_value_i;
    end
    if (ctrl_i.read) begin
      rd_seen_q <= in_range && valid_q[idx];
      rd_cnt_q  <= cnt_mem[idx];
      rd_min_q  <= min_mem[idx];
      rd_max_q  <= max_mem[idx];
    end
    if (ctrl_i.commit) begin
      if (record) begin
        cnt_mem[idx] <= new_cnt;
        min_mem[idx] <= new_min;
        max_mem[idx] <= new_max;
        seen_q       <= 1'b1;
        cnt_q        <= new_cnt;
        min_q        <= new_min;
        max_q        <= new_max;
      end else if (rd_seen_q) begin
        seen_q <= 1'b1;
        cnt_q  <= rd_cnt_q;
        min_q  <= rd_min_q;
        max_q  <= rd_max_q;
      end else begin
        // Unseen device, or a number beyond the table: all zero.
        seen_q <= 1'b0;
        cnt_q  <= '0;
        min_q  <= '0;
        max_q  <= '0;
      end
    end
  end

  assign seen_o        = seen_q;
  assign event_count_o = cnt_q;
  assign min_seen_o    = min_q;
  assign max_seen_o    = max_q;

endmodule

// File: hdl/per_device_min_max_tracker.sv
// ----------------------------------------------------------------------------
// per_device_min_max_tracker
// Each request is handled in order: the request is captured, the device's
// table entry is read into a register, and the update is written back while
// the result is loaded into the output register. The single-port table
// read-modify-write sets this sequence. A new request is taken as soon as the
// previous one has reached the output register, even if its result still
// waits to be taken; a result that waits holds the next request in its
// update cycle. The table needs no clearing pass: a valid bit per entry
// marks devices that have been seen.
// ----------------------------------------------------------------------------
module per_device_min_max_tracker #(
  parameter int DEVICES    = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ptk_in_if.sink   in_i,
  ptk_out_if.source out_o
);
  import ptk_pkg::*;

  ctrl_t ctrl;

  ptk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .ctrl_o     (ctrl)
  );

  ptk_datapath #(
    .DEVICES   (DEVICES),
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (in_i.cmd),
    .device_id_i   (in_i.device_id),
    .sample_value_i(in_i.sample_value),
    .seen_o        (out_o.seen),
    .event_count_o (out_o.event_count),
    .min_seen_o    (out_o.min_seen),
    .max_seen_o    (out_o.max_seen)
  );

endmodule

// File: hdl/ptk_checker.sv
// ----------------------------------------------------------------------------
// ptk_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptk_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         seen_i,
  input logic [31:0]                  event_count_i,
  input logic signed [VALUE_BITS-1:0] min_seen_i,
  input logic signed [VALUE_BITS-1:0] max_seen_i
);

  logic [2*VALUE_BITS+32:0] payload;

  assign payload = {seen_i, event_count_i, min_seen_i, max_seen_i};

  // A stalled result keeps its payload.
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(payload))

  // Only one request is in flight in the update path.
  `ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)

  // An unseen device reports all zero.
  `ASSERT_SAME(a_unseen_zero, out_valid_i && !seen_i, event_count_i == 0 && min_seen_i == 0 && max_seen_i == 0)

  // A seen device has a count and an ordered range.
  `ASSERT_SAME(a_seen_range, out_valid_i && seen_i, event_count_i != 0 && min_seen_i <= max_seen_i)

endmodule

bind per_device_min_max_tracker ptk_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_ptk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .seen_i       (out_o.seen),
  .event_count_i(out_o.event_count),
  .min_seen_i   (out_o.min_seen),
  .max_seen_i   (out_o.max_seen)
);
